/* sv/rcfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfr_pkg
// Shared types and constants of the radio command frame receiver.
// ----------------------------------------------------------------------------
package rcfr_pkg;

    localparam int SYNC_BYTES_DEF = 8;
    localparam int PAYLOAD_BYTES  = 4;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_INDEX_W    = 8;

    localparam logic [7:0] DUTY_RESET   = 8'd129;
    localparam logic [7:0] TIMING_RESET = 8'd30;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_PATTERN    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_XOR_MASK        = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SILENCE_TIMEOUT = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SAVE_DELAY      = 8'd3;

    // opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] duty;
        logic       output_enable;
        logic       code_valid;
        logic       save_commit;
        logic [7:0] saved_duty;
    } result_t;

    typedef struct packed {
        logic [31:0] xor_mask;
        logic [7:0]  silence_timeout;
        logic [7:0]  save_delay;
    } cfg_t;

endpackage

/* sv/rcfr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfr_if
// Valid/ready channels: input items and result items.
// ----------------------------------------------------------------------------
interface rcfr_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface rcfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] duty;
    logic       output_enable;
    logic       code_valid;
    logic       save_commit;
    logic [7:0] saved_duty;

    modport source (output valid, output duty, output output_enable, output code_valid,
                    output save_commit, output saved_duty, input ready);
    modport sink   (input valid, input duty, input output_enable, input code_valid,
                    input save_commit, input saved_duty, output ready);
endinterface

/* sv/rcfr_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfr_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module rcfr_cfg #(
    parameter int SYNC_BYTES = rcfr_pkg::SYNC_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rcfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rcfr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output logic [SYNC_BYTES*8-1:0]           sync_pattern,
    output rcfr_pkg::cfg_t                    cfg
);

    logic [SYNC_BYTES*8-1:0] sync_reg;
    rcfr_pkg::cfg_t          cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg                <= '0;
            cfg_reg.xor_mask        <= '0;
            cfg_reg.silence_timeout <= rcfr_pkg::TIMING_RESET;
            cfg_reg.save_delay      <= rcfr_pkg::TIMING_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rcfr_pkg::REG_SYNC_PATTERN:    sync_reg <= cfg_wdata[SYNC_BYTES*8-1:0];
                rcfr_pkg::REG_XOR_MASK:        cfg_reg.xor_mask <= cfg_wdata[31:0];
                rcfr_pkg::REG_SILENCE_TIMEOUT: cfg_reg.silence_timeout <= cfg_wdata[7:0];
                rcfr_pkg::REG_SAVE_DELAY:      cfg_reg.save_delay <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign sync_pattern = sync_reg;
    assign cfg          = cfg_reg;

endmodule

/* sv/rcfr_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfr_engine
// Frame matcher, descrambler, counters and duty commit; one item per cycle while fire is high.
// ----------------------------------------------------------------------------
module rcfr_engine #(
    parameter int SYNC_BYTES = rcfr_pkg::SYNC_BYTES_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [SYNC_BYTES*8-1:0] sync_pattern,
    input  rcfr_pkg::cfg_t          cfg,
    input  logic                    fire,
    input  rcfr_pkg::item_t         item,
    output rcfr_pkg::result_t       result
);

    localparam int POS_W  = $clog2(SYNC_BYTES + rcfr_pkg::PAYLOAD_BYTES);
    localparam int SIDX_W = (SYNC_BYTES > 1) ? $clog2(SYNC_BYTES) : 1;
    localparam logic [POS_W-1:0] POS_SYNC = POS_W'(SYNC_BYTES);
    localparam logic [POS_W-1:0] POS_LAST =
        POS_W'(SYNC_BYTES + rcfr_pkg::PAYLOAD_BYTES - 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       store_reg [rcfr_pkg::PAYLOAD_BYTES];
    logic [7:0]       silence_reg, silence_next;
    logic [7:0]       save_reg, save_next;
    logic [7:0]       recv_reg, recv_next;
    logic [7:0]       commit_reg, commit_next;
    logic             en_reg, en_next;

    logic [7:0]       sync_bytes [SYNC_BYTES];
    logic [SIDX_W-1:0] sidx;
    logic [POS_W-1:0] pos_off;
    logic [1:0]       k;
    logic [7:0]       plain;
    logic             store_we;
    logic             valid;
    logic             commit;

    always_comb
    begin
        for (int i = 0; i < SYNC_BYTES; i++)
        begin
            sync_bytes[i] = sync_pattern[i*8 +: 8];
        end
    end

    assign sidx    = pos_reg[SIDX_W-1:0];
    assign pos_off = pos_reg - POS_SYNC;
    assign k       = pos_off[1:0];
    assign plain   = item.rx_byte ^ cfg.xor_mask[k*8 +: 8];

    always_comb
    begin
        pos_next     = pos_reg;
        silence_next = silence_reg;
        save_next    = save_reg;
        recv_next    = recv_reg;
        en_next      = en_reg;
        store_we     = 1'b0;
        valid        = 1'b0;

        if (item.opcode == rcfr_pkg::OP_TICK)
        begin
            if (silence_reg < cfg.silence_timeout)
                silence_next = silence_reg + 8'd1;
            if (save_reg < cfg.save_delay)
                save_next = save_reg + 8'd1;
        end
        else if (pos_reg < POS_SYNC)
        begin
            if (sync_bytes[sidx] == item.rx_byte)
                pos_next = pos_reg + POS_W'(1);
            else
                pos_next = '0;
        end
        else
        begin
            store_we = 1'b1;
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg == POS_LAST)
            begin
                pos_next = '0;
                // last payload byte is in plain, not yet in the store
                if (store_reg[1] == store_reg[0] && store_reg[2] == store_reg[0] &&
                    plain == store_reg[0])
                begin
                    valid     = 1'b1;
                    recv_next = store_reg[0];
                    if (store_reg[0] != commit_reg)
                        save_next = '0;
                    if (silence_reg >= cfg.silence_timeout)
                        en_next = ~en_reg;
                    silence_next = '0;
                end
            end
        end

        commit      = (save_next >= cfg.save_delay) && (commit_reg != recv_next);
        commit_next = commit ? recv_next : commit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            silence_reg <= '0;
            save_reg    <= '0;
            recv_reg    <= rcfr_pkg::DUTY_RESET;
            commit_reg  <= rcfr_pkg::DUTY_RESET;
            en_reg      <= 1'b1;
        end
        else if (fire)
        begin
            pos_reg     <= pos_next;
            silence_reg <= silence_next;
            save_reg    <= save_next;
            recv_reg    <= recv_next;
            commit_reg  <= commit_next;
            en_reg      <= en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && store_we)
            store_reg[k] <= plain;
    end

    assign result.duty          = recv_next;
    assign result.output_enable = en_next;
    assign result.code_valid    = valid;
    assign result.save_commit   = commit;
    assign result.saved_duty    = commit_next;

endmodule

/* sv/radio_command_frame_receiver_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_command_frame_receiver_core
// Sync matcher and duty/enable control for a radio command link.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                         | notes
//  in_ch    | in  | opcode, rx_byte                                 | valid/ready
//  out_ch   | out | duty, output_enable, code_valid, save_commit,   | valid/ready
//           |     | saved_duty                                      |
//  cfg      | in  | cfg_we, cfg_index, cfg_wdata                    | write only
//
// One item per cycle unless the result stalls; input register, then the engine
// logic into the result register, which holds one result per transaction.
// The state is updated as an item moves into the result register.
// A stalled result holds the chain; in_ch.ready = !in_v_reg || advance.
// Reset is asynchronous; no clearing pass.
// ----------------------------------------------------------------------------
module radio_command_frame_receiver_core #(
    parameter int SYNC_BYTES = rcfr_pkg::SYNC_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    rcfr_in_if.sink                          in_ch,
    rcfr_out_if.source                       out_ch,
    input  logic                             cfg_we,
    input  logic [rcfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rcfr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic [SYNC_BYTES*8-1:0] sync_pattern;
    rcfr_pkg::cfg_t          cfg;

    logic                    in_v_reg;
    rcfr_pkg::item_t         item_reg;
    logic                    out_v_reg;
    rcfr_pkg::result_t       res_reg;
    rcfr_pkg::result_t       res_next;
    logic                    advance;
    logic                    fire;

    assign advance     = !out_v_reg || out_ch.ready;
    assign fire        = in_v_reg && advance;
    assign in_ch.ready = !in_v_reg || advance;

    rcfr_cfg #(.SYNC_BYTES(SYNC_BYTES)) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .sync_pattern (sync_pattern),
        .cfg          (cfg)
    );

    rcfr_engine #(.SYNC_BYTES(SYNC_BYTES)) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .sync_pattern (sync_pattern),
        .cfg          (cfg),
        .fire         (fire),
        .item         (item_reg),
        .result       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
                in_v_reg <= in_ch.valid;
            if (advance)
                out_v_reg <= in_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg.opcode  <= in_ch.opcode;
            item_reg.rx_byte <= in_ch.rx_byte;
        end
        if (fire)
            res_reg <= res_next;
    end

    assign out_ch.valid         = out_v_reg;
    assign out_ch.duty          = res_reg.duty;
    assign out_ch.output_enable = res_reg.output_enable;
    assign out_ch.code_valid    = res_reg.code_valid;
    assign out_ch.save_commit   = res_reg.save_commit;
    assign out_ch.saved_duty    = res_reg.saved_duty;

endmodule

/* sv/rcfr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfr_checker
// Port-level checks on the result channel of the receiver core.
// ----------------------------------------------------------------------------
module rcfr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] duty,
    input logic       output_enable,
    input logic       code_valid,
    input logic       save_commit,
    input logic [7:0] saved_duty
);

    logic       out_txn;
    logic [7:0] last_saved_reg;
    logic       last_en_reg;

    assign out_txn = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_saved_reg <= rcfr_pkg::DUTY_RESET;
            last_en_reg    <= 1'b1;
        end
        else if (out_txn)
        begin
            last_saved_reg <= saved_duty;
            last_en_reg    <= output_enable;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(duty) && $stable(saved_duty)
            && $stable(output_enable) && $stable(code_valid) && $stable(save_commit))
        else $error("result changed while stalled");

    a_commit_dup: assert property (@(posedge clk) disable iff (!rst_n)
        out_txn && save_commit |-> saved_duty == duty)
        else $error("commit does not match duty");

    a_saved_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        out_txn && !save_commit |-> saved_duty == last_saved_reg)
        else $error("saved duty moved without commit");

    a_enable_only_on_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_txn && !code_valid |-> output_enable == last_en_reg)
        else $error("output enable moved without valid code");

endmodule

bind radio_command_frame_receiver_core rcfr_checker u_rcfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .duty          (out_ch.duty),
    .output_enable (out_ch.output_enable),
    .code_valid    (out_ch.code_valid),
    .save_commit   (out_ch.save_commit),
    .saved_duty    (out_ch.saved_duty)
);
